// File: design/bsa_pkg.sv
package bsa_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int CHANNELS    = 4;
    localparam int STORE_WORDS = MAX_WIDTH * MAX_HEIGHT * CHANNELS;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int DIM_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;

    typedef enum logic {
        OP_SPLAT = 1'b0,
        OP_READ  = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_READ_WAIT,
        ST_SPLAT,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic       load;
        logic       clear;
        logic       corner_vld;
        logic [1:0] corner;
        logic       rd_item;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_sts;

    function automatic logic [ADDR_W-1:0] word_addr(
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] col,
        input logic [1:0]       ch
    );
        logic [ADDR_W-1:0] pix;
        pix = ADDR_W'(row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
        return pix * ADDR_W'(CHANNELS) + ADDR_W'(ch);
    endfunction

endpackage

// File: design/bsa_ctrl.sv
module bsa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_opcode,
    input  bsa_pkg::t_sts i_sts,
    output logic          o_in_stall,
    output bsa_pkg::t_cmd o_cmd
);

    bsa_pkg::t_state r_state, n_state;
    logic [1:0]      r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsa_pkg::ST_CLEAR;
            r_cnt   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            bsa_pkg::ST_CLEAR: begin
                if (i_sts.clear_last) begin
                    n_state = bsa_pkg::ST_IDLE;
                end
            end
            bsa_pkg::ST_IDLE: begin
                n_cnt = 2'd0;
                if (i_in_valid && i_sts.out_free) begin
                    if (i_opcode == bsa_pkg::OP_READ) begin
                        n_state = bsa_pkg::ST_READ;
                    end else begin
                        n_state = bsa_pkg::ST_SPLAT;
                    end
                end
            end
            bsa_pkg::ST_READ: begin
                n_state = bsa_pkg::ST_READ_WAIT;
            end
            bsa_pkg::ST_READ_WAIT: begin
                n_state = bsa_pkg::ST_IDLE;
            end
            bsa_pkg::ST_SPLAT: begin
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    n_state = bsa_pkg::ST_DRAIN;
                    n_cnt   = 2'd0;
                end
            end
            bsa_pkg::ST_DRAIN: begin
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd2) begin
                    n_state = bsa_pkg::ST_IDLE;
                    n_cnt   = 2'd0;
                end
            end
            default: begin
                n_state = bsa_pkg::ST_IDLE;
                n_cnt   = 2'd0;
            end
        endcase
    end

    always_comb begin
        o_in_stall       = !((r_state == bsa_pkg::ST_IDLE) && i_sts.out_free);
        o_cmd            = '0;
        o_cmd.load       = (r_state == bsa_pkg::ST_IDLE) && i_sts.out_free && i_in_valid;
        o_cmd.clear      = (r_state == bsa_pkg::ST_CLEAR);
        o_cmd.corner_vld = (r_state == bsa_pkg::ST_SPLAT);
        o_cmd.corner     = r_cnt;
        o_cmd.rd_item    = (r_state == bsa_pkg::ST_READ);
        o_cmd.out_load   = (r_state == bsa_pkg::ST_READ_WAIT);
    end

endmodule

// File: design/bsa_datapath.sv
module bsa_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bsa_pkg::t_cmd             i_cmd,
    input  logic [bsa_pkg::DIM_W-1:0] i_eff_w,
    input  logic [bsa_pkg::DIM_W-1:0] i_eff_h,
    input  logic signed [23:0]        i_splat_value,
    input  logic signed [19:0]        i_pos_x,
    input  logic signed [19:0]        i_pos_y,
    input  logic [1:0]                i_channel,
    input  logic [7:0]                i_read_col,
    input  logic [7:0]                i_read_row,
    input  logic                      i_out_stall,
    output bsa_pkg::t_sts             o_sts,
    output logic                      o_out_valid,
    output logic signed [31:0]        o_read_data
);

    localparam int AW = bsa_pkg::ADDR_W;

    logic [31:0] r_acc_mem [bsa_pkg::STORE_WORDS];

    logic signed [23:0] r_val;
    logic [11:0]        r_x0, r_y0;
    logic [7:0]         r_dx, r_dy;
    logic [1:0]         r_ch;
    logic [7:0]         r_rcol, r_rrow;

    logic [12:0]   cx, cy;
    logic          ch_ok, in_x, in_y;
    logic [8:0]    wx, wy;
    logic [17:0]   weight;
    logic [AW-1:0] corner_addr, item_addr, rd_addr;

    logic          r_a_vld;
    logic [16:0]   r_a_weight;
    logic [AW-1:0] r_a_addr;

    logic signed [17:0] w_s;
    logic signed [41:0] prod;
    logic               r_b_vld;
    logic signed [41:0] r_b_prod;
    logic [AW-1:0]      r_b_addr;

    logic signed [41:0] rnd;
    logic               r_c_vld;
    logic signed [24:0] r_c_contrib;
    logic [AW-1:0]      r_c_addr;

    logic [31:0]        r_rd_data;
    logic signed [32:0] sum;
    logic [31:0]        sat;

    logic [AW-1:0] r_clr_addr;
    logic          rd_ok;
    logic          r_out_vld;
    logic [31:0]   r_out_data;

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val  <= i_splat_value;
            r_x0   <= i_pos_x[19:8];
            r_y0   <= i_pos_y[19:8];
            r_dx   <= i_pos_x[7:0];
            r_dy   <= i_pos_y[7:0];
            r_ch   <= i_channel;
            r_rcol <= i_read_col;
            r_rrow <= i_read_row;
        end
    end

    // corner select and weight
    always_comb begin
        cx     = {r_x0[11], r_x0} + 13'(i_cmd.corner[0]);
        cy     = {r_y0[11], r_y0} + 13'(i_cmd.corner[1]);
        ch_ok  = ({1'b0, r_ch} < 3'(bsa_pkg::CHANNELS));
        in_x   = !cx[12] && (cx < i_eff_w);
        in_y   = !cy[12] && (cy < i_eff_h);
        wx     = i_cmd.corner[0] ? {1'b0, r_dx} : 9'd256 - {1'b0, r_dx};
        wy     = i_cmd.corner[1] ? {1'b0, r_dy} : 9'd256 - {1'b0, r_dy};
        weight = 18'(wx) * 18'(wy);
        corner_addr = bsa_pkg::word_addr(cy[bsa_pkg::ROW_W-1:0], cx[bsa_pkg::COL_W-1:0], r_ch);
        item_addr   = bsa_pkg::word_addr(bsa_pkg::ROW_W'(r_rrow), bsa_pkg::COL_W'(r_rcol), r_ch);
        rd_addr     = i_cmd.rd_item ? item_addr : r_b_addr;
        rd_ok       = ch_ok && (bsa_pkg::DIM_W'(r_rcol) < i_eff_w)
                      && (bsa_pkg::DIM_W'(r_rrow) < i_eff_h);
    end

    always_comb begin
        w_s  = $signed({1'b0, r_a_weight});
        prod = r_val * w_s;
        rnd  = r_b_prod + 42'sd32768;
        sum  = {r_rd_data[31], r_rd_data} + {{8{r_c_contrib[24]}}, r_c_contrib};
        if (sum[32] != sum[31]) begin
            sat = sum[32] ? 32'h8000_0000 : 32'h7fff_ffff;
        end else begin
            sat = sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld    <= 1'b0;
            r_b_vld    <= 1'b0;
            r_c_vld    <= 1'b0;
            r_clr_addr <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_a_vld <= i_cmd.corner_vld && ch_ok && in_x && in_y;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_weight  <= weight[16:0];
        r_a_addr    <= corner_addr;
        r_b_prod    <= prod;
        r_b_addr    <= r_a_addr;
        r_c_contrib <= rnd[40:16];
        r_c_addr    <= r_b_addr;
        if (i_cmd.out_load) begin
            r_out_data <= rd_ok ? r_rd_data : 32'd0;
        end
    end

    // accumulator store
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_acc_mem[rd_addr];
        if (i_cmd.clear) begin
            r_acc_mem[r_clr_addr] <= 32'd0;
        end else if (r_c_vld) begin
            r_acc_mem[r_c_addr] <= sat;
        end
    end

    assign o_sts.clear_last = (r_clr_addr == AW'(bsa_pkg::STORE_WORDS - 1));
    assign o_sts.out_free   = !r_out_vld || !i_out_stall;
    assign o_out_valid      = r_out_vld;
    assign o_read_data      = r_out_data;

endmodule

// File: design/bilinear_splat_accumulator.sv
// Bilinear splat accumulator. After reset the block sweeps its accumulator
// memory to zero, one word per cycle, over all MAX_WIDTH*MAX_HEIGHT*CHANNELS
// words (262144 at the default sizes); no word is taken during that sweep,
// while configuration writes are taken at any time. A splat word occupies the
// block until its corners have passed through: its four corners enter a weight,
// multiply, round and read-modify-write pipeline one per cycle on the single
// accumulator memory, which then drains. A read word reads the accumulator
// memory in the READ state and loads its result into an output register in the
// READ_WAIT state; while a result waits there untaken, no further word is taken.
module bilinear_splat_accumulator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_opcode,
    input  logic signed [23:0]            i_splat_value,
    input  logic signed [19:0]            i_pos_x,
    input  logic signed [19:0]            i_pos_y,
    input  logic [1:0]                    i_channel,
    input  logic [7:0]                    i_read_col,
    input  logic [7:0]                    i_read_row,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [31:0]            o_read_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bsa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bsa_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [8:0]                r_img_w, r_img_h;
    logic [bsa_pkg::DIM_W-1:0] eff_w, eff_h;
    bsa_pkg::t_cmd             cmd;
    bsa_pkg::t_sts             sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= 9'd256;
            r_img_h <= 9'd256;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bsa_pkg::REG_IMAGE_WIDTH:  r_img_w <= i_cfg_data;
                bsa_pkg::REG_IMAGE_HEIGHT: r_img_h <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    always_comb begin
        eff_w = (bsa_pkg::DIM_W'(r_img_w) > bsa_pkg::DIM_W'(bsa_pkg::MAX_WIDTH))
                ? bsa_pkg::DIM_W'(bsa_pkg::MAX_WIDTH) : bsa_pkg::DIM_W'(r_img_w);
        eff_h = (bsa_pkg::DIM_W'(r_img_h) > bsa_pkg::DIM_W'(bsa_pkg::MAX_HEIGHT))
                ? bsa_pkg::DIM_W'(bsa_pkg::MAX_HEIGHT) : bsa_pkg::DIM_W'(r_img_h);
    end

    bsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    bsa_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_eff_w       (eff_w),
        .i_eff_h       (eff_h),
        .i_splat_value (i_splat_value),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_channel     (i_channel),
        .i_read_col    (i_read_col),
        .i_read_row    (i_read_row),
        .i_out_stall   (i_out_stall),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .o_read_data   (o_read_data)
    );

endmodule
